// ===== hdl/oes_pkg.sv =====
package oes_pkg;

  // Field and register widths
  localparam int XW   = 32;
  localparam int HW   = 31;
  localparam int MW   = 2;
  localparam int IDXW = 2;
  localparam int IN_DW  = 64;
  localparam int OUT_DW = 72;

  // Fourth-order weighted sum: k1 + 2k2 + 2k3 + k4 fits in 35 signed bits
  localparam int ACCW = 35;

  // Divide-by-six unit: quotient bits produced per cycle and total width
  localparam int DIV_DIGITS = 8;
  localparam int DIVW       = 40;
  localparam int DIV_STEPS  = DIVW / DIV_DIGITS;
  localparam int DIV_CNTW   = $clog2(DIV_STEPS);
  localparam logic [3:0] DIV_BY = 4'd6;
  localparam logic [DIVW-1:0] DIV_BIAS = DIVW'(3);

  // Input item kinds
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Integration methods; code 3 runs as fourth-order Runge-Kutta
  localparam logic [MW-1:0] METH_EULER = 2'd0;
  localparam logic [MW-1:0] METH_HEUN  = 2'd1;
  localparam logic [MW-1:0] METH_RK4   = 2'd2;

  // Configuration register indexes
  localparam logic [IDXW-1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [IDXW-1:0] REG_END_X     = 2'd1;
  localparam logic [IDXW-1:0] REG_METHOD    = 2'd2;

  // Configuration reset values
  localparam logic [HW-1:0]        STEP_SIZE_RST = 31'd6554;
  localparam logic signed [XW-1:0] END_X_RST     = 32'sd13107;
  localparam logic [MW-1:0]        METHOD_RST    = METH_EULER;

  typedef enum logic {XS_PLUS_HALF_H, XS_PLUS_H} xsel_t;
  typedef enum logic {YS_PLUS_HALF_K, YS_PLUS_K} ysel_t;
  typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_ADD2} acc_op_t;

  // Controller to datapath command word
  typedef struct packed {
    logic    start;
    logic    load_xy;
    logic    deriv;
    logic    save_f1;
    logic    sum_f;
    logic    mul;
    logic    rnd;
    logic    rnd_half;
    logic    prep;
    xsel_t   prep_x;
    ysel_t   prep_y;
    acc_op_t acc_op;
    logic    div_load;
    logic    div_step;
    logic    q_sat;
    logic    commit;
    logic    out_load;
    logic    out_adv;
  } dp_cmd_t;

  // Saturated value with its overflow flag
  typedef struct packed {
    logic signed [XW-1:0] val;
    logic                 ovf;
  } sat_t;

  // Clamp a 33-bit sum to the 32-bit signed range.
  function automatic sat_t sat33(input logic signed [XW:0] v);
    sat_t r;
    r.ovf = v[XW] != v[XW-1];
    if (!r.ovf) begin
      r.val = v[XW-1:0];
    end else if (v[XW]) begin
      r.val = {1'b1, {(XW-1){1'b0}}};
    end else begin
      r.val = {1'b0, {(XW-1){1'b1}}};
    end
    return r;
  endfunction

  // Clamp a 64-bit value to the 32-bit signed range.
  function automatic sat_t sat64(input logic signed [63:0] v);
    sat_t r;
    r.ovf = (v[63:XW-1] != {(64-XW+1){1'b0}}) && (v[63:XW-1] != {(64-XW+1){1'b1}});
    if (!r.ovf) begin
      r.val = v[XW-1:0];
    end else if (v[63]) begin
      r.val = {1'b1, {(XW-1){1'b0}}};
    end else begin
      r.val = {1'b0, {(XW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== hdl/oes_div6.sv =====
module oes_div6 (
  input  logic                    clk,
  input  logic                    div_load,
  input  logic                    div_step,
  input  logic [oes_pkg::DIVW-1:0] num,
  output logic [oes_pkg::DIVW-1:0] quot
);
  import oes_pkg::*;

  logic [DIVW-1:0] shift_r;
  logic [DIVW-1:0] shift_nxt;
  logic [2:0]      rem_r;
  logic [2:0]      rem_nxt;
  logic [3:0]      trial;

  // Restoring division by six, several quotient bits per cycle.
  // Dividend bits leave at the top while quotient bits enter at the bottom.
  always_comb begin
    rem_nxt   = rem_r;
    shift_nxt = shift_r;
    trial     = 4'd0;
    for (int i = 0; i < DIV_DIGITS; i++) begin
      trial     = {rem_nxt, shift_nxt[DIVW-1]};
      shift_nxt = {shift_nxt[DIVW-2:0], 1'b0};
      if (trial >= DIV_BY) begin
        trial        = trial - DIV_BY;
        shift_nxt[0] = 1'b1;
      end
      rem_nxt = trial[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      shift_r <= num;
      rem_r   <= 3'd0;
    end else if (div_step) begin
      shift_r <= shift_nxt;
      rem_r   <= rem_nxt;
    end
  end

  assign quot = shift_r;

endmodule

// ===== hdl/oes_datapath.sv =====
module oes_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  oes_pkg::dp_cmd_t                  cmd,
  input  logic signed [oes_pkg::XW-1:0]     start_x,
  input  logic signed [oes_pkg::XW-1:0]     start_y,
  input  logic [oes_pkg::HW-1:0]            step_size,
  input  logic signed [oes_pkg::XW-1:0]     end_x,
  output logic                              x_below_end,
  output logic [oes_pkg::OUT_DW-1:0]        out_data
);
  import oes_pkg::*;

  localparam logic signed [63:0] RND_FB  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] RND_FB1 = 64'sd1 <<< FRAC_BITS;
  localparam int OUT_PAD = OUT_DW - 2 * XW - 3;
  localparam int QPAD    = 64 - DIVW;

  // State and working registers
  logic signed [XW-1:0]   x_r, x_nxt;
  logic signed [XW-1:0]   y_r, y_nxt;
  logic                   sat_r, sat_nxt;
  logic signed [XW-1:0]   xe_r, ye_r;
  logic signed [XW-1:0]   f_r, f1_r;
  logic signed [63:0]     prod_r;
  logic signed [XW-1:0]   k_r;
  logic signed [ACCW-1:0] acc_r;
  logic                   neg_r;
  logic [OUT_DW-1:0]      out_data_r;

  // Combinational terms
  logic [XW-1:0]          hh_sum;
  logic [HW-1:0]          half_h;
  logic signed [XW-1:0]   h_s;
  sat_t                   xph, xphh, yphk, ypk, dv, sf, rv, qs;
  logic signed [XW:0]     k_p1;
  logic signed [XW:0]     half_k;
  logic signed [63:0]     prod;
  logic signed [63:0]     rq_fb, rq_fb1;
  logic signed [ACCW-1:0] k_ext;
  logic [ACCW-1:0]        acc_abs;
  logic [DIVW-1:0]        div_num;
  logic [DIVW-1:0]        div_quot;
  logic signed [63:0]     q_mag, q_val;
  sat_t                   xsel, ysel;

  // Step size and half step, both non-negative
  assign hh_sum = {1'b0, step_size} + XW'(1);
  assign half_h = hh_sum[XW-1:1];
  assign h_s    = {1'b0, step_size};

  // Evaluation points for the later derivative samples
  assign xph  = sat33({x_r[XW-1], x_r} + $signed({2'b00, step_size}));
  assign xphh = sat33({x_r[XW-1], x_r} + $signed({2'b00, half_h}));
  assign k_p1   = {k_r[XW-1], k_r} + (XW+1)'(1);
  assign half_k = k_p1 >>> 1;
  assign yphk = sat33({y_r[XW-1], y_r} + half_k);
  assign ypk  = sat33({y_r[XW-1], y_r} + {k_r[XW-1], k_r});
  assign xsel = (cmd.prep_x == XS_PLUS_H) ? xph : xphh;
  assign ysel = (cmd.prep_y == YS_PLUS_K) ? ypk : yphk;

  // Derivative x + y, and the Heun slope sum
  assign dv = sat33({xe_r[XW-1], xe_r} + {ye_r[XW-1], ye_r});
  assign sf = sat33({f1_r[XW-1], f1_r} + {f_r[XW-1], f_r});

  // Shared multiplier and its rounding back to fixed point
  assign prod   = h_s * f_r;
  assign rq_fb  = (prod_r + RND_FB) >>> FRAC_BITS;
  assign rq_fb1 = (prod_r + RND_FB1) >>> (FRAC_BITS + 1);
  assign rv     = cmd.rnd_half ? sat64(rq_fb1) : sat64(rq_fb);

  // Weighted slope sum and its division by six, rounded half away from zero
  assign k_ext   = ACCW'(k_r);
  assign acc_abs = acc_r[ACCW-1] ? ACCW'(-acc_r) : ACCW'(acc_r);
  assign div_num = {{(DIVW-ACCW){1'b0}}, acc_abs} + DIV_BIAS;

  oes_div6 u_div (
    .clk      (clk),
    .div_load (cmd.div_load),
    .div_step (cmd.div_step),
    .num      (div_num),
    .quot     (div_quot)
  );

  assign q_mag = {{QPAD{1'b0}}, div_quot};
  assign q_val = neg_r ? -q_mag : q_mag;
  assign qs    = sat64(q_val);

  // Next state of x, y and the clamp flag
  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    sat_nxt = sat_r;
    if (cmd.load_xy) begin
      x_nxt = start_x;
      y_nxt = start_y;
    end
    if (cmd.commit) begin
      x_nxt = xph.val;
      y_nxt = ypk.val;
    end
    if (cmd.start) begin
      sat_nxt = 1'b0;
    end else begin
      sat_nxt = sat_r
              | (cmd.deriv  & dv.ovf)
              | (cmd.sum_f  & sf.ovf)
              | (cmd.rnd    & rv.ovf)
              | (cmd.prep   & (xsel.ovf | ysel.ovf))
              | (cmd.q_sat  & qs.ovf)
              | (cmd.commit & (xph.ovf | ypk.ovf));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= '0;
      y_r   <= '0;
      sat_r <= 1'b0;
    end else begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      sat_r <= sat_nxt;
    end
  end

  // Working registers of the update
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      xe_r <= x_r;
      ye_r <= y_r;
    end else if (cmd.prep) begin
      xe_r <= xsel.val;
      ye_r <= ysel.val;
    end
    if (cmd.deriv) begin
      f_r <= dv.val;
    end else if (cmd.sum_f) begin
      f_r <= sf.val;
    end
    if (cmd.save_f1) begin
      f1_r <= dv.val;
    end
    if (cmd.mul) begin
      prod_r <= prod;
    end
    if (cmd.rnd) begin
      k_r <= rv.val;
    end else if (cmd.q_sat) begin
      k_r <= qs.val;
    end
    case (cmd.acc_op)
      ACC_LOAD: acc_r <= k_ext;
      ACC_ADD:  acc_r <= acc_r + k_ext;
      ACC_ADD2: acc_r <= acc_r + (k_ext <<< 1);
      default:  acc_r <= acc_r;
    endcase
    if (cmd.div_load) begin
      neg_r <= acc_r[ACCW-1];
    end
    if (cmd.out_load) begin
      out_data_r <= {{OUT_PAD{1'b0}}, cmd.out_adv & sat_r, ~x_below_end, cmd.out_adv,
                     x_r, y_r};
    end
  end

  assign x_below_end = x_r < end_x;
  assign out_data    = out_data_r;

endmodule

// ===== hdl/oes_ctrl.sv =====
module oes_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic                    in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic [oes_pkg::MW-1:0]  method,
  input  logic                    x_below_end,
  output oes_pkg::dp_cmd_t        cmd
);
  import oes_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DERIV, S_SUMF, S_MUL, S_RND, S_PREP, S_ACC,
    S_DIVLD, S_DIV, S_QSAT, S_COMMIT, S_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          stage_r, stage_nxt;
  logic [DIV_CNTW-1:0] div_cnt_r, div_cnt_nxt;
  logic                adv_r, adv_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                is_euler, is_heun;

  assign is_euler = method == METH_EULER;
  assign is_heun  = method == METH_HEUN;

  // Sequencing of the update; stage_r counts derivative samples
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    div_cnt_nxt   = div_cnt_r;
    adv_nxt       = adv_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    in_tready     = state_r == S_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          stage_nxt = 2'd0;
          if (in_tuser == CMD_LOAD) begin
            cmd.load_xy = 1'b1;
            adv_nxt     = 1'b0;
            state_nxt   = S_FINISH;
          end else if (x_below_end) begin
            adv_nxt   = 1'b1;
            state_nxt = S_DERIV;
          end else begin
            adv_nxt   = 1'b0;
            state_nxt = S_FINISH;
          end
        end
      end
      S_DERIV: begin
        cmd.deriv   = 1'b1;
        cmd.save_f1 = stage_r == 2'd0;
        state_nxt   = (is_heun && stage_r == 2'd1) ? S_SUMF : S_MUL;
      end
      S_SUMF: begin
        cmd.sum_f = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd      = 1'b1;
        cmd.rnd_half = is_heun && stage_r == 2'd1;
        if (is_euler) begin
          state_nxt = S_COMMIT;
        end else if (is_heun) begin
          state_nxt = (stage_r == 2'd0) ? S_PREP : S_COMMIT;
        end else begin
          state_nxt = (stage_r == 2'd3) ? S_ACC : S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (is_heun) begin
          cmd.prep_x = XS_PLUS_H;
          cmd.prep_y = YS_PLUS_K;
        end else begin
          if (stage_r == 2'd2) begin
            cmd.prep_x = XS_PLUS_H;
            cmd.prep_y = YS_PLUS_K;
          end else begin
            cmd.prep_x = XS_PLUS_HALF_H;
            cmd.prep_y = YS_PLUS_HALF_K;
          end
          cmd.acc_op = (stage_r == 2'd0) ? ACC_LOAD : ACC_ADD2;
        end
        stage_nxt = stage_r + 2'd1;
        state_nxt = S_DERIV;
      end
      S_ACC: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_load = 1'b1;
        div_cnt_nxt  = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == DIV_CNTW'(DIV_STEPS - 1)) begin
          state_nxt = S_QSAT;
        end else begin
          div_cnt_nxt = div_cnt_r + DIV_CNTW'(1);
        end
      end
      S_QSAT: begin
        cmd.q_sat = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        // Wait only while an earlier result is still held in the output register
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.out_adv = adv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage_r     <= 2'd0;
      div_cnt_r   <= '0;
      adv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      div_cnt_r   <= div_cnt_nxt;
      adv_r       <= adv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // A pending result is never overwritten.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while still pending");

  // A load item goes straight to the result without an update.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == CMD_LOAD) |=> (state_r == S_FINISH && !adv_r))
    else $error("load item did not go straight to the result");

  // The divider step count stays within range while dividing.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_cnt_r < DIV_CNTW'(DIV_STEPS)))
    else $error("divider count out of range");

  // Update states are only reached for an item that advances.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT || state_r == S_PREP || state_r == S_MUL) |-> adv_r)
    else $error("update running for an item that does not advance");

  // At most three evaluation points are prepared per step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP) |-> (stage_r != 2'd3))
    else $error("too many derivative samples");

endmodule

// ===== hdl/ode_explicit_stepper_unit.sv =====
// Explicit ODE stepper for dy/dx = x + y, with x and y held in signed fixed point.
// Input channel in_*: in_tuser selects the item kind (load or step), in_tdata
// carries the start point used by a load. Each item gives exactly one result on
// out_*, holding the current y and x and the advanced, finished and clamp flags.
// A step applies one Euler, Heun or fourth-order Runge-Kutta update while x is
// below the end point, then advances x by the step size.
// Items are processed one at a time. The updates share a single multiplier,
// used once per derivative sample with a register on each side; a Runge-Kutta
// update also uses the divide-by-six unit, which produces eight quotient bits
// per cycle.
// The result sits in an output register; a new item is accepted while it waits.
// If the receiver stalls, the next result waits in the last state until the
// register frees. Synchronous reset clears x and y to zero, restores the
// configuration defaults and empties the output register. The user must write
// configuration through cfg_* only while the block is idle; the block itself
// does not enforce this.
module ode_explicit_stepper_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: start_x [31:0], start_y [63:32]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [oes_pkg::IN_DW-1:0]       in_tdata,
  // in_tuser: command [0]
  input  logic                            in_tuser,
  // out_tdata: y_value [31:0], x_value [63:32], advanced [64], finished [65],
  //            saturated [66], zero [71:67]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [oes_pkg::OUT_DW-1:0]      out_tdata,
  input  logic                            cfg_we,
  input  logic [oes_pkg::IDXW-1:0]        cfg_index,
  input  logic [oes_pkg::XW-1:0]          cfg_wdata
);
  import oes_pkg::*;

  logic [HW-1:0]        step_size_r;
  logic signed [XW-1:0] end_x_r;
  logic [MW-1:0]        method_r;
  dp_cmd_t              cmd;
  logic                 x_below_end;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r <= STEP_SIZE_RST;
      end_x_r     <= END_X_RST;
      method_r    <= METHOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_SIZE: step_size_r <= cfg_wdata[HW-1:0];
        REG_END_X:     end_x_r     <= cfg_wdata;
        REG_METHOD:    method_r    <= cfg_wdata[MW-1:0];
        default:       ;
      endcase
    end
  end

  oes_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .method      (method_r),
    .x_below_end (x_below_end),
    .cmd         (cmd)
  );

  oes_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .start_x     (in_tdata[XW-1:0]),
    .start_y     (in_tdata[2*XW-1:XW]),
    .step_size   (step_size_r),
    .end_x       (end_x_r),
    .x_below_end (x_below_end),
    .out_data    (out_tdata)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import oes_pkg::*;

  localparam int FRAC = 16;
  // Method code with no method of its own; the block runs it as Runge-Kutta.
  localparam logic [MW-1:0] METH_SPARE = 2'd3;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // One solver output, laid out as on out_tdata.
  typedef struct packed {
    logic       saturated;
    logic       finished;
    logic       advanced;
    logic [XW-1:0] x_value;
    logic [XW-1:0] y_value;
  } ode_point_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  logic              in_tuser = CMD_LOAD;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic              cfg_we = 1'b0;
  logic [IDXW-1:0]   cfg_index = REG_STEP_SIZE;
  logic [XW-1:0]     cfg_wdata = '0;

  // Mirror of the solver state and its registers.
  longint          sol_x = 0;
  longint          sol_y = 0;
  longint          h_q = longint'(STEP_SIZE_RST);
  longint          x_end = longint'(END_X_RST);
  logic [MW-1:0]   method_q = METHOD_RST;
  bit              clamp_hit;

  ode_point_t      expected_points[$];
  int              mismatches = 0;
  bit              gaps_on = 1'b1;
  bit              hold_req = 1'b0;
  int              quiet_cycles = 0;

  ode_explicit_stepper_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Clamp to the 32-bit signed range and note any clamp.
  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) begin
      clamp_hit = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      clamp_hit = 1'b1;
      return Q_MIN;
    end
    return v;
  endfunction

  // Divide by 2^s, rounding ties toward plus infinity.
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint q_mul(longint a, longint b, int s);
    return clamp_q(round_shift(a * b, s));
  endfunction

  // The fixed derivative dy/dx = x + y.
  function automatic longint slope(longint x, longint y);
    return clamp_q(x + y);
  endfunction

  function automatic longint y_increment(longint x, longint y, longint h);
    longint f1, f2, hh, xm, k1, k2, k3, k4, wsum;
    case (method_q)
      METH_EULER: begin
        return q_mul(h, slope(x, y), FRAC);
      end
      METH_HEUN: begin
        f1 = slope(x, y);
        f2 = slope(clamp_q(x + h), clamp_q(y + q_mul(h, f1, FRAC)));
        // Average of the two slopes folded into one extra shift.
        return q_mul(h, clamp_q(f1 + f2), FRAC + 1);
      end
      default: begin
        hh = round_shift(h, 1);
        xm = clamp_q(x + hh);
        k1 = q_mul(h, slope(x, y), FRAC);
        k2 = q_mul(h, slope(xm, clamp_q(y + round_shift(k1, 1))), FRAC);
        k3 = q_mul(h, slope(xm, clamp_q(y + round_shift(k2, 1))), FRAC);
        k4 = q_mul(h, slope(clamp_q(x + h), clamp_q(y + k3)), FRAC);
        wsum = k1 + 2 * k2 + 2 * k3 + k4;
        // Division by six rounds ties away from zero.
        if (wsum >= 0) begin
          return clamp_q((wsum + 3) / 6);
        end
        return clamp_q(-((-wsum + 3) / 6));
      end
    endcase
  endfunction

  // Apply one item to the mirrored state and return the point it yields.
  function automatic ode_point_t integrate_item(logic cmd, logic [XW-1:0] sx,
                                                logic [XW-1:0] sy);
    ode_point_t p;
    logic adv;
    adv = 1'b0;
    clamp_hit = 1'b0;
    if (cmd == CMD_LOAD) begin
      sol_x = longint'($signed(sx));
      sol_y = longint'($signed(sy));
    end else if (sol_x < x_end) begin
      sol_y = clamp_q(sol_y + y_increment(sol_x, sol_y, h_q));
      sol_x = clamp_q(sol_x + h_q);
      adv = 1'b1;
    end
    p.y_value = sol_y[XW-1:0];
    p.x_value = sol_x[XW-1:0];
    p.advanced = adv;
    p.finished = (sol_x >= x_end);
    p.saturated = adv && clamp_hit;
    return p;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 70) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Fixed-point value: mostly small, sometimes scaled, sometimes extreme.
  function automatic logic [XW-1:0] random_q();
    int r;
    logic signed [XW-1:0] t;
    r = $urandom_range(0, 99);
    t = $urandom;
    if (r < 60) begin
      return $urandom_range(0, 1 << 20) - (1 << 19);
    end
    if (r < 85) begin
      return t >>> $urandom_range(0, 31);
    end
    if (r < 95) begin
      return t;
    end
    return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  task automatic write_reg(logic [IDXW-1:0] idx, logic [XW-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STEP_SIZE: begin
        h_q = longint'(value[HW-1:0]);
      end
      REG_END_X: begin
        x_end = longint'($signed(value));
      end
      default: begin
        method_q = value[MW-1:0];
      end
    endcase
  endtask

  task automatic configure(logic [XW-1:0] h, logic [XW-1:0] e, logic [MW-1:0] m);
    write_reg(REG_STEP_SIZE, h);
    write_reg(REG_END_X, e);
    write_reg(REG_METHOD, XW'(m));
  endtask

  // Offer one item, wait for it to be taken and record its expected point.
  task automatic send_item(logic cmd, logic [XW-1:0] sx, logic [XW-1:0] sy);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {sy, sx};
    do @(posedge clk); while (!in_tready);
    expected_points = {expected_points, integrate_item(cmd, sx, sy)};
  endtask

  // Stop offering and wait until every expected point has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_points.size() != 0);
  endtask

  // Default registers: two steps reach the end, the third is past it.
  task automatic test_reset_state();
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, '0, 32'h0001_0000);
    send_item(CMD_STEP, '0, '0);
  endtask

  // One load and one step under each method code, the spare one included.
  task automatic test_methods();
    logic [MW-1:0] codes[4];
    codes = '{METH_HEUN, METH_RK4, METH_SPARE, METH_EULER};
    foreach (codes[i]) begin
      settle();
      configure(32'h0000_8000, 32'h0003_0000, codes[i]);
      send_item(CMD_LOAD, 32'h0000_4000, 32'h0001_0000);
      send_item(CMD_STEP, '0, '0);
    end
  endtask

  task automatic test_extremes();
    // Zero step size: the step runs but neither x nor y moves.
    settle();
    configure('0, 32'h7FFF_FFFF, METH_RK4);
    send_item(CMD_LOAD, 32'h0005_0000, 32'h0002_0000);
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_STEP, '0, '0);
    // Largest step: x clamps at the top, then stepping is over.
    settle();
    configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, METH_RK4);
    send_item(CMD_LOAD, 32'h7FFF_FF00, 32'h7FFF_FFFF);
    send_item(CMD_STEP, '0, '0);
    send_item(CMD_STEP, '0, '0);
    // Most negative start: y clamps at the bottom.
    send_item(CMD_LOAD, 32'h8000_0000, 32'h8000_0000);
    send_item(CMD_STEP, '0, '0);
    settle();
    configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, METH_HEUN);
    send_item(CMD_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_STEP, '0, '0);
    // Lowest end point: every x is finished, no step is taken.
    settle();
    configure(32'h0000_0001, 32'h8000_0000, METH_EULER);
    send_item(CMD_LOAD, '0, '0);
    send_item(CMD_STEP, '0, '0);
  endtask

  // The receiver holds off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    settle();
    configure(32'h0000_199A, 32'h7FFF_FFFF, METH_RK4);
    gaps_on = 1'b0;
    hold_req = 1'b1;
    send_item(CMD_LOAD, '0, 32'h0001_0000);
    repeat (11) send_item(CMD_STEP, '0, '0);
    gaps_on = 1'b1;
    settle();
  endtask

  task automatic random_setting(logic [MW-1:0] m);
    int r;
    logic [XW-1:0] h, e;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      h = $urandom_range(1, 1 << 17);
    end else if (r < 85) begin
      h = $urandom_range(1, 1 << 24);
    end else if (r < 95) begin
      h = $urandom & 32'h7FFF_FFFF;
    end else begin
      h = '0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      e = $urandom_range(0, 1 << 22) - (1 << 21);
    end else if (r < 90) begin
      e = $urandom;
    end else if (r < 95) begin
      e = 32'h7FFF_FFFF;
    end else begin
      e = 32'h8000_0000;
    end
    configure(h, e, m);
  endtask

  // Mostly a load placed a few steps short of the end followed by steps
  // that run past it; the rest is single items with random content.
  task automatic run_sequences(int budget);
    int sent, nsteps, extra;
    longint base;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 7) begin
        nsteps = $urandom_range(1, 6);
        extra = $urandom_range(0, 2);
        base = x_end - longint'(nsteps) * h_q;
        if (h_q > 0) begin
          base += longint'($urandom_range(0, 32'(h_q - 1)));
        end else begin
          base -= 1;
        end
        base = clamp_q(base);
        send_item(CMD_LOAD, base[XW-1:0], random_q());
        repeat (nsteps + extra) send_item(CMD_STEP, $urandom, $urandom);
        sent += 1 + nsteps + extra;
      end else begin
        send_item(logic'($urandom_range(0, 1)), $urandom, $urandom);
        sent++;
      end
      if ($urandom_range(0, 19) == 0) begin
        settle();
      end
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      gaps_on = ($urandom_range(0, 3) != 0);
      random_setting(MW'(ph % 4));
      run_sequences(30);
    end
    gaps_on = 1'b1;
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_methods();
    test_extremes();
    test_backpressure();
    test_random();
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Result side: compare each point taken and drive out_tready with gaps.
  initial begin : result_monitor
    ode_point_t want, got;
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.y_value = out_tdata[31:0];
        got.x_value = out_tdata[63:32];
        got.advanced = out_tdata[64];
        got.finished = out_tdata[65];
        got.saturated = out_tdata[66];
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected item: y=%h x=%h adv=%b fin=%b sat=%b",
                     got.y_value, got.x_value, got.advanced, got.finished,
                     got.saturated);
          end
        end else begin
          want = expected_points.pop_front();
          if (got.y_value !== want.y_value || got.x_value !== want.x_value ||
              got.advanced !== want.advanced || got.finished !== want.finished ||
              got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch: expected y=%h x=%h adv=%b fin=%b sat=%b",
                       want.y_value, want.x_value, want.advanced, want.finished,
                       want.saturated);
              $display("          actual   y=%h x=%h adv=%b fin=%b sat=%b",
                       got.y_value, got.x_value, got.advanced, got.finished,
                       got.saturated);
            end
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Ends the run when no item moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hdl/oes_pkg.sv
hdl/oes_div6.sv
hdl/oes_datapath.sv
hdl/oes_ctrl.sv
hdl/ode_explicit_stepper_unit.sv
sim/testbench.sv
